// ----- src/wsfa_pkg.sv -----
// ----------------------------------------------------------------------------
// wsfa_pkg: shared constants and types
// Widths, register indexes, action codes and control structs of the
// windowed scan fraction average block.
// ----------------------------------------------------------------------------
package wsfa_pkg;

  // ring depth, number of per-query sums that can be held
  localparam int WINDOW_DEPTH = 64;

  localparam int SIZE_W   = 32;
  localparam int SUM_W    = 40;
  localparam int TV_W     = 32;
  localparam int WS_W     = 7;
  localparam int FRAC_W   = 20;
  localparam int QIW_W    = 7;
  localparam int FRAC_Q   = 16;

  localparam int SLOT_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int COUNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int TOTAL_W   = SUM_W + $clog2(WINDOW_DEPTH);
  localparam int DIVISOR_W = TV_W + COUNT_W;
  localparam int REM_W     = TOTAL_W + FRAC_Q;
  localparam int DSH_W     = DIVISOR_W + FRAC_W;
  localparam int CMP_W     = (REM_W > DSH_W) ? REM_W : DSH_W;
  localparam int BIT_W     = $clog2(FRAC_W);

  // configuration
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_VEC_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN   = CFG_IDX_W'(1);
  localparam logic [TV_W-1:0]      TV_RESET      = TV_W'(1);
  localparam logic [WS_W-1:0]      WS_RESET      = WS_W'(64);

  // input actions
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef struct packed {
    logic start;
    logic ack;
  } wsfa_div_req_t;

  typedef struct packed {
    logic              valid;
    logic [FRAC_W-1:0] frac;
  } wsfa_div_rsp_t;

endpackage

// ----- src/wsfa_in_if.sv -----
// ----------------------------------------------------------------------------
// wsfa_in_if: input channel
// Valid/ready channel carrying one scanned size element or a clear action.
// ----------------------------------------------------------------------------
interface wsfa_in_if import wsfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [SIZE_W-1:0] scanned_size;
  logic              last_of_query;

  modport source (output valid, action, scanned_size, last_of_query, input ready);
  modport sink   (input valid, action, scanned_size, last_of_query, output ready);
endinterface

// ----- src/wsfa_out_if.sv -----
// ----------------------------------------------------------------------------
// wsfa_out_if: result channel
// Valid/ready channel carrying the window mean scan fraction of one query.
// ----------------------------------------------------------------------------
interface wsfa_out_if import wsfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FRAC_W-1:0] scan_fraction;
  logic [QIW_W-1:0]  queries_in_window;

  modport source (output valid, scan_fraction, queries_in_window, input ready);
  modport sink   (input valid, scan_fraction, queries_in_window, output ready);
endinterface

// ----- src/windowed_scan_fraction_average.sv -----
// ----------------------------------------------------------------------------
// windowed_scan_fraction_average: sliding window mean scan fraction
// Sums scanned partition sizes per query, keeps a ring of the last window
// of query sums and reports their mean fraction of the index as Q4.16.
// ----------------------------------------------------------------------------
// usage:
// - in_if carries one beat per scanned partition (action add) or a clear
//   beat (action clear); last_of_query marks the final beat of a query
// - out_if carries one beat per finished query: scan_fraction (Q4.16,
//   saturated at 0xfffff) and queries_in_window
// - cfg port: write enable, register index, data; index vector count at
//   index 0, window length at index 1; writing the window length while ready
//   is high clears the history
// - after a non-final add beat or a clear beat, ready stays high
// - a final beat's result is offered after a ring update, then the divider
//   forms the divisor product, does the saturation check, runs the restoring
//   division (one quotient bit per cycle) and hands the result off; a
//   saturating mean skips the division
// - ready is low until the result is handed off, so a new beat is not
//   accepted while a query result is still being formed
// - the result sits in an output register; add beats are accepted while it
//   waits; a finished division waits for the output register to drain
// - reset clears the query sum, count and window total; the ring itself is
//   not cleared, only entries written since the last clear are ever read
// ----------------------------------------------------------------------------
module windowed_scan_fraction_average import wsfa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  wsfa_in_if.sink               in_if,
  wsfa_out_if.source            out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  // sequencer and history state
  logic [1:0]         state_q, state_d;
  logic [SUM_W-1:0]   acc_q, acc_d;
  logic [SUM_W-1:0]   qsum_q, qsum_d;
  logic [SLOT_W-1:0]  oldest_q, oldest_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  // configuration registers
  logic [TV_W-1:0]    tv_q;
  logic [WS_W-1:0]    ws_q;
  logic [COUNT_W-1:0] w_eff;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [FRAC_W-1:0]  out_frac_q, out_frac_d;
  logic [QIW_W-1:0]   out_qiw_q, out_qiw_d;
  logic               out_free;

  // ring and divider
  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  logic [SUM_W-1:0]   ram_rdata;
  wsfa_div_req_t      div_req;
  wsfa_div_rsp_t      div_rsp;

  logic               in_beat;
  logic               cfg_clear;
  logic [SUM_W:0]     acc_sum;
  logic [SUM_W-1:0]   acc_sat;
  logic               full;

  assign in_if.ready = (state_q == S_IDLE);
  assign in_beat     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_q || out_if.ready;
  assign cfg_clear   = cfg_we_i && (cfg_idx_i == REG_WIN_LEN);

  // window size of zero acts as one, above the ring depth as the depth
  always_comb begin
    if (32'(ws_q) > 32'(WINDOW_DEPTH)) begin
      w_eff = COUNT_W'(WINDOW_DEPTH);
    end else if (ws_q == '0) begin
      w_eff = COUNT_W'(1);
    end else begin
      w_eff = COUNT_W'(ws_q);
    end
  end

  // saturating per-query sum
  assign acc_sum = {1'b0, acc_q} + (SUM_W + 1)'(in_if.scanned_size);
  assign acc_sat = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];

  assign full      = (count_q >= w_eff);
  assign ram_we    = (state_q == S_UPD);
  assign ram_waddr = full ? oldest_q : count_q[SLOT_W-1:0];

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    qsum_d      = qsum_q;
    oldest_d    = oldest_q;
    count_d     = count_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    out_frac_d  = out_frac_q;
    out_qiw_d   = out_qiw_q;
    div_req     = '0;

    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cfg_clear) begin
          acc_d    = '0;
          oldest_d = '0;
          count_d  = '0;
          total_d  = '0;
        end else if (in_beat) begin
          if (in_if.action == ACT_CLEAR) begin
            acc_d    = '0;
            oldest_d = '0;
            count_d  = '0;
            total_d  = '0;
          end else if (in_if.last_of_query) begin
            // ring read of the oldest slot is under way this cycle
            qsum_d  = acc_sat;
            acc_d   = '0;
            state_d = S_UPD;
          end else begin
            acc_d = acc_sat;
          end
        end
      end
      S_UPD: begin
        if (full) begin
          // replace the oldest sum
          total_d = total_q - TOTAL_W'(ram_rdata) + TOTAL_W'(qsum_q);
          if (COUNT_W'(oldest_q) + COUNT_W'(1) == w_eff) begin
            oldest_d = '0;
          end else begin
            oldest_d = oldest_q + SLOT_W'(1);
          end
        end else begin
          total_d = total_q + TOTAL_W'(qsum_q);
          count_d = count_q + COUNT_W'(1);
        end
        div_req.start = 1'b1;
        state_d       = S_WAIT;
      end
      S_WAIT: begin
        if (div_rsp.valid && out_free) begin
          out_valid_d = 1'b1;
          out_frac_d  = div_rsp.frac;
          out_qiw_d   = QIW_W'(count_q);
          div_req.ack = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      oldest_q    <= '0;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      tv_q        <= TV_RESET;
      ws_q        <= WS_RESET;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_idx_i == REG_VEC_COUNT)) begin
        tv_q <= cfg_wdata_i[TV_W-1:0];
      end
      if (cfg_clear) begin
        ws_q <= cfg_wdata_i[WS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qsum_q     <= qsum_d;
    out_frac_q <= out_frac_d;
    out_qiw_q  <= out_qiw_d;
  end

  // per-query sums of the window
  wsfa_ram #(
    .WIDTH (SUM_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (qsum_q),
    .raddr_i (oldest_q),
    .rdata_o (ram_rdata)
  );

  // single multiply and restoring divide unit
  wsfa_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (div_req),
    .total_i (total_q),
    .count_i (count_q),
    .tv_i    (tv_q),
    .rsp_o   (div_rsp)
  );

  assign out_if.valid             = out_valid_q;
  assign out_if.scan_fraction     = out_frac_q;
  assign out_if.queries_in_window = out_qiw_q;

endmodule

// ----- src/wsfa_ram.sv -----
// ----------------------------------------------------------------------------
// wsfa_ram: generic single-write, single-read ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wsfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/wsfa_divider.sv -----
// ----------------------------------------------------------------------------
// wsfa_divider: iterative fraction divider
// Forms the index vector count times the query count, then divides the window
// total by it one quotient bit per cycle, giving a saturated unsigned Q4.16
// fraction.
// ----------------------------------------------------------------------------
module wsfa_divider import wsfa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wsfa_div_req_t       req_i,
  input  logic [TOTAL_W-1:0]  total_i,
  input  logic [COUNT_W-1:0]  count_i,
  input  logic [TV_W-1:0]     tv_i,
  output wsfa_div_rsp_t       rsp_o
);

  localparam logic [2:0] D_IDLE = 3'd0;
  localparam logic [2:0] D_MUL  = 3'd1;
  localparam logic [2:0] D_CHK  = 3'd2;
  localparam logic [2:0] D_DIV  = 3'd3;
  localparam logic [2:0] D_DONE = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [DIVISOR_W-1:0] dvs_q, dvs_d;
  logic [CMP_W-1:0]     rem_q, rem_d;
  logic [CMP_W-1:0]     div_q, div_d;
  logic [FRAC_W-1:0]    quo_q, quo_d;
  logic [BIT_W-1:0]     bit_q, bit_d;
  logic [TV_W-1:0]      tv_eff;
  logic [CMP_W-1:0]     div_top;
  logic                 ge;

  assign tv_eff  = (tv_i == '0) ? TV_W'(1) : tv_i;
  assign div_top = CMP_W'(dvs_q) << FRAC_W;
  assign ge      = (rem_q >= div_q);

  always_comb begin
    state_d = state_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    div_d   = div_q;
    quo_d   = quo_q;
    bit_d   = bit_q;
    unique case (state_q)
      D_IDLE: begin
        if (req_i.start) begin
          state_d = D_MUL;
        end
      end
      D_MUL: begin
        // count is never zero here, a query has just been recorded
        dvs_d   = DIVISOR_W'(tv_eff) * DIVISOR_W'(count_i);
        rem_d   = CMP_W'(total_i) << FRAC_Q;
        state_d = D_CHK;
      end
      D_CHK: begin
        // mean of 16 or more saturates
        if (rem_q >= div_top) begin
          quo_d   = '1;
          state_d = D_DONE;
        end else begin
          div_d   = CMP_W'(dvs_q) << (FRAC_W - 1);
          bit_d   = BIT_W'(FRAC_W - 1);
          state_d = D_DIV;
        end
      end
      D_DIV: begin
        if (ge) begin
          rem_d = rem_q - div_q;
        end
        quo_d = {quo_q[FRAC_W-2:0], ge};
        div_d = div_q >> 1;
        bit_d = bit_q - BIT_W'(1);
        if (bit_q == '0) begin
          state_d = D_DONE;
        end
      end
      D_DONE: begin
        if (req_i.ack) begin
          state_d = D_IDLE;
        end
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
    bit_q <= bit_d;
  end

  assign rsp_o.valid = (state_q == D_DONE);
  assign rsp_o.frac  = quo_q;

endmodule

// ----- dv/windowed_scan_fraction_average_tb.sv -----
// ----------------------------------------------------------------------------
// windowed_scan_fraction_average_tb: self-checking testbench
// Drives scanned size beats, clear beats and register writes into the block,
// predicts each query result with an independent window model and compares
// every result beat field by field, under random idling and long stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module windowed_scan_fraction_average_tb;
  import wsfa_pkg::*;

  localparam int     CLK_PERIOD   = 10;
  localparam int     RESET_CYCLES = 12;
  // leave margin after the last result before touching registers
  localparam int     DRAIN_SLACK  = 32;
  localparam int     IDLE_PCT     = 22;
  localparam int     MAX_GAP      = 8;
  localparam longint CYCLE_LIMIT  = 400000;

  // indexes past the register list, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [FRAC_W-1:0] FRAC_SAT = {FRAC_W{1'b1}};

  typedef struct packed {
    logic [FRAC_W-1:0] scan_fraction;
    logic [QIW_W-1:0]  queries_in_window;
  } fraction_beat_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  wsfa_in_if  in_if ();
  wsfa_out_if out_if ();

  windowed_scan_fraction_average uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // window model state, mirrors the block's history
  logic [SUM_W-1:0]   query_sum;
  logic [SUM_W-1:0]   sum_ring [WINDOW_DEPTH];
  int unsigned        oldest_idx;
  int unsigned        queries_held;
  logic [TOTAL_W-1:0] window_sum;
  logic [TV_W-1:0]    vectors_cfg;
  logic [WS_W-1:0]    window_cfg;

  // results predicted but not yet seen on the output channel
  fraction_beat_t pending_fractions [$];

  int unsigned  mismatches      = 0;
  int unsigned  beats_sent      = 0;
  int unsigned  clears_sent     = 0;
  int unsigned  results_checked = 0;
  int unsigned  cfg_writes      = 0;
  longint       cycle_count     = 0;

  // idle_enable is shared by the sender and the receiver, the hold counters serve the receiver
  bit           idle_enable  = 1'b1;
  int unsigned  hold_request = 0;
  int unsigned  hold_count   = 0;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // run limit, catches a hung handshake
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               pending_fractions.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  task automatic forget_history();
    query_sum    = '0;
    oldest_idx   = 0;
    queries_held = 0;
    window_sum   = '0;
  endtask

  // mean of the window as Q4.16, truncated, saturated at the top code
  function automatic logic [FRAC_W-1:0] average_fraction(input logic [TOTAL_W-1:0] sum,
                                                         input int unsigned count);
    logic [63:0] divisor;
    logic [63:0] quot;
    logic [63:0] rem;
    divisor = 64'((vectors_cfg == '0) ? TV_W'(1) : vectors_cfg) *
              64'((count == 0) ? 1 : count);
    quot = 64'(sum) / divisor;
    rem  = 64'(sum) % divisor;
    if (quot >= 64'd16) return FRAC_SAT;
    return FRAC_W'((quot << FRAC_Q) + ((rem << FRAC_Q) / divisor));
  endfunction

  // advance the model by one accepted beat, queue the result of a query end
  task automatic track_beat(input logic act, input logic [SIZE_W-1:0] size,
                            input logic last);
    logic [SUM_W:0]   wide;
    logic [SUM_W-1:0] qsum;
    int unsigned      span;
    int unsigned      slot;
    fraction_beat_t   res;
    beats_sent++;
    if (act == ACT_CLEAR) begin
      clears_sent++;
      forget_history();
      return;
    end
    wide      = {1'b0, query_sum} + (SUM_W + 1)'(size);
    query_sum = wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
    if (!last) return;
    qsum      = query_sum;
    query_sum = '0;
    // window size of 0 acts as 1, above the ring depth as the depth
    if (window_cfg == '0) span = 1;
    else if (window_cfg > WINDOW_DEPTH) span = WINDOW_DEPTH;
    else span = window_cfg;
    if (queries_held < span) begin
      slot           = queries_held % WINDOW_DEPTH;
      sum_ring[slot] = qsum;
      window_sum     = window_sum + TOTAL_W'(qsum);
      queries_held++;
    end else begin
      // full window: the oldest query sum drops out
      slot           = oldest_idx % WINDOW_DEPTH;
      window_sum     = window_sum - TOTAL_W'(sum_ring[slot]) + TOTAL_W'(qsum);
      sum_ring[slot] = qsum;
      oldest_idx     = (slot + 1) % span;
    end
    res.scan_fraction     = average_fraction(window_sum, queries_held);
    res.queries_in_window = QIW_W'(queries_held);
    pending_fractions.push_back(res);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : result_check
    fraction_beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_fractions.size() == 0) begin
        report_mismatch($sformatf("result beat with none expected, fraction 0x%05h qiw %0d",
                                  out_if.scan_fraction, out_if.queries_in_window));
      end else begin
        want = pending_fractions.pop_front();
        results_checked++;
        if (out_if.scan_fraction !== want.scan_fraction)
          report_mismatch($sformatf("result %0d scan_fraction 0x%05h, expected 0x%05h",
                                    results_checked, out_if.scan_fraction,
                                    want.scan_fraction));
        if (out_if.queries_in_window !== want.queries_in_window)
          report_mismatch($sformatf("result %0d queries_in_window %0d, expected %0d",
                                    results_checked, out_if.queries_in_window,
                                    want.queries_in_window));
      end
    end
  end

  // receiver: random ready, or held low for a counted stretch on request
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_count   = hold_request;
      hold_request = 0;
    end
    if (hold_count != 0) begin
      hold_count--;
      out_if.ready <= 1'b0;
    end else if (idle_enable) begin
      out_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- drivers

  // offer one beat, optionally after a random gap, and wait for acceptance
  task automatic send_beat(input logic act, input logic [SIZE_W-1:0] size,
                           input logic last);
    int unsigned gap;
    gap = 0;
    if (idle_enable)
      while (gap < MAX_GAP && $urandom_range(0, 99) < IDLE_PCT) gap++;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.action        <= act;
    in_if.scanned_size  <= size;
    in_if.last_of_query <= last;
    do @(posedge clk_i); while (!in_if.ready);
    track_beat(act, size, last);
  endtask

  // stop sending, let every expected result arrive, then let the block go idle
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_fractions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  // register write, only called while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cfg_writes++;
    case (idx)
      REG_VEC_COUNT: vectors_cfg = data[TV_W-1:0];
      REG_WIN_LEN: begin
        // a new window size also drops the history
        window_cfg = data[WS_W-1:0];
        forget_history();
      end
      default: ;
    endcase
  endtask

  function automatic logic [SIZE_W-1:0] pick_size(input logic [SIZE_W-1:0] scale);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 12) return SIZE_MAX;
    if (roll < 22) return $urandom;
    return $urandom_range(0, scale);
  endfunction

  // ---------------------------------------------------------------- tests

  // reset register values, fraction corners, clears, spare indexes, window
  // size limits
  task automatic test_directed();
    send_beat(ACT_ADD, '0, 1'b1);                   // zero fraction
    send_beat(ACT_ADD, 32'd1, 1'b0);                // two beat query
    send_beat(ACT_ADD, '0, 1'b1);
    send_beat(ACT_CLEAR, SIZE_MAX, 1'b1);           // clear ignores size and last
    send_beat(ACT_ADD, 32'd15, 1'b1);               // just under the ceiling
    send_beat(ACT_ADD, 32'd16, 1'b1);
    send_beat(ACT_CLEAR, '0, 1'b0);
    send_beat(ACT_ADD, SIZE_MAX, 1'b1);             // large mean saturates
    send_beat(ACT_ADD, 32'd5, 1'b0);                // partial query dropped by clear
    send_beat(ACT_CLEAR, '0, 1'b0);
    send_beat(ACT_ADD, 32'd1, 1'b1);
    settle();
    write_reg(REG_VEC_COUNT, '0);                   // zero divisor acts as one
    write_reg(REG_SPARE_A, 32'd5);
    write_reg(REG_SPARE_B, '1);
    send_beat(ACT_ADD, 32'd3, 1'b1);                // history kept across a divisor write
    send_beat(ACT_ADD, 32'd2, 1'b1);
    settle();
    write_reg(REG_WIN_LEN, 32'd1);                  // single slot replacement
    send_beat(ACT_ADD, 32'd3, 1'b1);
    send_beat(ACT_ADD, 32'd7, 1'b1);
    settle();
    write_reg(REG_WIN_LEN, '0);                     // zero window acts as one
    send_beat(ACT_ADD, 32'd9, 1'b1);
    send_beat(ACT_ADD, 32'd4, 1'b1);
    settle();
    write_reg(REG_VEC_COUNT, SIZE_MAX);
    write_reg(REG_WIN_LEN, 32'd127);                // oversize window acts as the depth
    send_beat(ACT_ADD, SIZE_MAX, 1'b1);
    send_beat(ACT_ADD, SIZE_MAX, 1'b1);
    settle();
  endtask

  // one long query of full beats pins the query sum at its maximum; enough
  // zero queries follow to pull the mean below the ceiling
  task automatic test_sum_saturation();
    write_reg(REG_VEC_COUNT, SIZE_MAX);
    write_reg(REG_WIN_LEN, CFG_DATA_W'(WINDOW_DEPTH));
    repeat (299) send_beat(ACT_ADD, SIZE_MAX, 1'b0);
    send_beat(ACT_ADD, SIZE_MAX, 1'b1);
    repeat (20) send_beat(ACT_ADD, '0, 1'b1);
    settle();
  endtask

  // fill the whole ring and wrap past it
  task automatic test_full_window();
    write_reg(REG_VEC_COUNT, 32'd8);
    write_reg(REG_WIN_LEN, CFG_DATA_W'(WINDOW_DEPTH));
    repeat (WINDOW_DEPTH + 16) send_beat(ACT_ADD, SIZE_W'($urandom_range(0, 16)), 1'b1);
    settle();
  endtask

  // long receiver stall while the sender keeps offering: the output register
  // fills, a finished division waits and the input stalls
  task automatic test_backpressure();
    hold_request = 300;
    repeat (60) send_beat(ACT_ADD, SIZE_W'($urandom_range(0, 100)), 1'(($urandom_range(0, 1))));
    settle();
  endtask

  // phases of random queries under random register settings; one phase runs
  // with no idling on either side
  task automatic test_random_traffic(input int unsigned budget);
    int unsigned       sent;
    int unsigned       phase;
    int unsigned       phase_len;
    int unsigned       qlen;
    int unsigned       k;
    logic [TV_W-1:0]   tv;
    logic [WS_W-1:0]   ws;
    logic [SIZE_W-1:0] scale;
    sent  = 0;
    phase = 0;
    while (sent < budget) begin
      settle();
      case ($urandom_range(0, 5))
        0:       tv = '0;
        1:       tv = TV_W'(1);
        2:       tv = '1;
        3:       tv = $urandom;
        default: tv = TV_W'($urandom_range(1, 5000));
      endcase
      write_reg(REG_VEC_COUNT, tv);
      // sometimes keep the window so the history spans a divisor change
      if (phase == 0 || $urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 7))
          0:       ws = '0;
          1:       ws = WS_W'(1);
          2:       ws = WS_W'(WINDOW_DEPTH);
          3:       ws = WS_W'(WINDOW_DEPTH + 1);
          4:       ws = '1;
          default: ws = WS_W'($urandom_range(2, 12));
        endcase
        // upper data bits are junk, only the register width counts
        write_reg(REG_WIN_LEN, CFG_DATA_W'({$urandom, ws}));
      end
      idle_enable = (phase != 1);
      phase_len   = (phase == 1) ? 200 : $urandom_range(40, 180);
      scale       = (tv == '0) ? SIZE_W'(1) : tv;
      k = 0;
      while (k < phase_len) begin
        qlen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 4);
        for (int b = 0; b < qlen; b++) begin
          // rare clears, often landing inside a query
          if ($urandom_range(0, 99) < 3)
            send_beat(ACT_CLEAR, $urandom, 1'($urandom_range(0, 1)));
          else
            send_beat(ACT_ADD, pick_size(scale), b == qlen - 1);
          k++;
        end
      end
      sent += k;
      phase++;
    end
    idle_enable = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= REG_VEC_COUNT;
    cfg_wdata_i         <= '0;
    in_if.valid         <= 1'b0;
    in_if.action        <= ACT_ADD;
    in_if.scanned_size  <= '0;
    in_if.last_of_query <= 1'b0;
    vectors_cfg = TV_RESET;
    window_cfg  = WS_RESET;
    forget_history();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_sum_saturation();
    test_full_window();
    test_backpressure();
    test_random_traffic(650);
    settle();

    $display("run covered %0d beats (%0d clears), %0d query results, %0d register writes",
             beats_sent, clears_sent, results_checked, cfg_writes);
    $display("incl. query sum saturation, full ring wrap, window size limits, long stalls");
    if (mismatches == 0 && pending_fractions.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_fractions.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/wsfa_pkg.sv
src/wsfa_in_if.sv
src/wsfa_out_if.sv
src/wsfa_ram.sv
src/wsfa_divider.sv
src/windowed_scan_fraction_average.sv
dv/windowed_scan_fraction_average_tb.sv
